// ===== sv/bcd_pkg.sv =====
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared types and constants of the binary cross dilation block: channel
// payloads, register map and result queue sizing.
// ----------------------------------------------------------------------------
package bcd_pkg;

   // pixel value that counts as set
   localparam logic [7:0] SET_VALUE = 8'd255;

   // register map
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned IMAGE_SIZE_W = 11;
   localparam logic [IMAGE_SIZE_W-1:0] IMAGE_SIZE_RESET = 11'd512;
   localparam logic REG_IMAGE_SIZE = 1'b0;

   // result queue
   localparam int unsigned QUEUE_DEPTH = 8;
   localparam int unsigned QUEUE_AW = 3;
   localparam int unsigned QUEUE_LW = 4;

   // request payload
   typedef struct packed {
      logic [7:0] pixel_value;
      logic       start_of_image;
   } req_payload_type;

   // result payload
   typedef struct packed {
      logic [7:0] out_value;
      logic       last_in_run;
      logic       end_of_image;
   } rsp_payload_type;

   // results of one request handed to the queue, first before second
   typedef struct packed {
      logic            first_valid;
      rsp_payload_type first;
      logic            second_valid;
      rsp_payload_type second;
   } push_type;

endpackage

// ===== sv/bcd_stream_if.sv =====
// ----------------------------------------------------------------------------
// bcd_stream_if
// Valid/ready stream channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface bcd_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/bcd_out_queue.sv =====
// ----------------------------------------------------------------------------
// bcd_out_queue
// Small result queue that takes up to two results per cycle and drives the
// result channel one result per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module bcd_out_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  bcd_pkg::push_type      push,
   output logic [bcd_pkg::QUEUE_LW-1:0] level,
   bcd_stream_if.source           rsp_ch
);
   import bcd_pkg::*;

   rsp_payload_type       entry_mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_LW-1:0]   level_ff, level_in;
   logic [QUEUE_AW-1:0]   second_addr;
   logic [1:0]            push_count;
   logic                  pop;

   // pop and push bookkeeping
   always_comb begin
      pop = rsp_ch.valid && rsp_ch.ready;
      push_count = {1'b0, push.first_valid} + {1'b0, push.second_valid};
      second_addr = wr_ptr_ff + QUEUE_AW'(push.first_valid);
      wr_ptr_in = wr_ptr_ff + QUEUE_AW'(push_count);
      rd_ptr_in = rd_ptr_ff + QUEUE_AW'(pop);
      level_in = level_ff + QUEUE_LW'(push_count) - QUEUE_LW'(pop);
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff <= level_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         entry_mem[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         entry_mem[second_addr] <= push.second;
      end
   end

   assign rsp_ch.valid = (level_ff != '0);
   assign rsp_ch.payload = entry_mem[rd_ptr_ff];
   assign level = level_ff;

endmodule

// ===== sv/binary_cross_dilation.sv =====
// ----------------------------------------------------------------------------
// binary_cross_dilation
// Streaming 3x3 cross binary dilation of a square 8-bit image in raster order.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one request per cycle while the queue has
// room. Row 0 is returned as it arrives, row 1 returns nothing, and each pixel
// of row r >= 2 returns output pixel (r-1,c); a pixel of the last row returns
// that result and then its own copy, so on the last row the result channel
// (at most one result a cycle) holds back the requests. One row of values and
// one row of set flags live in two single-clock memories indexed by column:
// the value memory is read at the column and the next column as the request
// is taken and written with the new pixel at the same edge, the flag memory
// is written in the next cycle from the value read. The result queue of eight
// entries lets requests keep flowing while results wait. image_size
// (register 0, byte address 0) must be written only while the block is idle;
// the block does not enforce this. 0 acts as 1 and values above MAX_WIDTH act
// as MAX_WIDTH. start_of_image restarts the row and column counts; after the
// last pixel of an image they wrap on their own.
// ----------------------------------------------------------------------------
module binary_cross_dilation #(
   parameter int unsigned MAX_WIDTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   bcd_stream_if.sink                       req_ch,
   bcd_stream_if.source                     rsp_ch,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bcd_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [bcd_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [bcd_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import bcd_pkg::*;

   localparam int unsigned AW = $clog2(MAX_WIDTH);
   localparam int unsigned NW = AW + 1;
   localparam int unsigned EW = (NW > IMAGE_SIZE_W) ? NW : IMAGE_SIZE_W;
   localparam logic [EW-1:0] MAX_EXT = EW'(MAX_WIDTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WIDTH - 1);

   // configuration
   logic [IMAGE_SIZE_W-1:0] image_size_ff;
   logic [EW-1:0]           size_ext;
   logic [NW-1:0]           n_eff;
   logic [NW-1:0]           n_last;
   logic                    csr_write;

   // position counts
   logic [AW-1:0] row_ff, row_in;
   logic [AW-1:0] col_ff, col_in;
   logic [AW-1:0] cur_row, cur_col, right_col;
   logic [NW-1:0] col_step, row_step;
   logic          restart;
   logic          req_fire;

   // row memories and their read data
   logic [7:0] value_mem [MAX_WIDTH];
   logic       flag_mem [MAX_WIDTH];
   logic [7:0] centre_rd_ff;
   logic [7:0] right_rd_ff;
   logic       up_rd_ff;

   // second stage
   logic          s1_valid_ff;
   logic [7:0]    s1_pixel_ff;
   logic [AW-1:0] s1_col_ff;
   logic          s1_dilate_ff;
   logic          s1_edge_col_ff;
   logic          s1_copy_ff;
   logic          s1_eoi_ff;
   logic          left_flag_ff;
   logic          centre_set;
   logic          any_set;
   logic [7:0]    dilated;

   // result queue
   push_type              push;
   logic [QUEUE_LW-1:0]   queue_level;
   logic [QUEUE_LW-1:0]   queue_claim;

   // register port
   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_size_ff <= IMAGE_SIZE_RESET;
      end else if (csr_write && (paddr[2] == REG_IMAGE_SIZE)) begin
         image_size_ff <= pwdata[IMAGE_SIZE_W-1:0];
      end
   end

   always_comb begin
      if (paddr[2] == REG_IMAGE_SIZE) begin
         prdata = CSR_DATA_W'(image_size_ff);
      end else begin
         prdata = '0;
      end
   end

   // effective image size
   always_comb begin
      size_ext = EW'(image_size_ff);
      if (size_ext == '0) begin
         n_eff = NW'(1);
      end else if (size_ext > MAX_EXT) begin
         n_eff = NW'(MAX_WIDTH);
      end else begin
         n_eff = size_ext[NW-1:0];
      end
      n_last = n_eff - NW'(1);
   end

   // admit a request while the queue can take its results
   assign queue_claim = queue_level + (s1_valid_ff ? QUEUE_LW'(2) : QUEUE_LW'(0));
   assign req_ch.ready = (queue_claim <= QUEUE_LW'(QUEUE_DEPTH - 2));
   assign req_fire = req_ch.valid && req_ch.ready;

   // position of the incoming pixel and of the next one
   always_comb begin
      restart = req_ch.payload.start_of_image || ({1'b0, row_ff} >= n_eff)
         || ({1'b0, col_ff} >= n_eff);
      cur_row = restart ? '0 : row_ff;
      cur_col = restart ? '0 : col_ff;
      right_col = (cur_col == LAST_ADDR) ? '0 : cur_col + AW'(1);
      col_step = {1'b0, cur_col} + NW'(1);
      row_step = {1'b0, cur_row} + NW'(1);
      if (col_step >= n_eff) begin
         col_in = '0;
         row_in = (row_step >= n_eff) ? '0 : row_step[AW-1:0];
      end else begin
         col_in = col_step[AW-1:0];
         row_in = cur_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (req_fire) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // value row: read centre and right, replace centre with the new pixel
   always_ff @(posedge clock) begin
      if (req_fire) begin
         centre_rd_ff <= value_mem[cur_col];
         right_rd_ff <= value_mem[right_col];
         value_mem[cur_col] <= req_ch.payload.pixel_value;
      end
   end

   // flag row: read up flag on request, write back the old centre flag next cycle
   always_ff @(posedge clock) begin
      if (req_fire) begin
         up_rd_ff <= flag_mem[cur_col];
      end
      if (s1_valid_ff) begin
         flag_mem[s1_col_ff] <= centre_set;
      end
   end

   // second stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_fire;
      end
   end

   // second stage payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pixel_ff <= req_ch.payload.pixel_value;
         s1_col_ff <= cur_col;
         s1_dilate_ff <= (cur_row >= AW'(2));
         s1_edge_col_ff <= (cur_col == '0) || ({1'b0, cur_col} == n_last);
         s1_copy_ff <= (cur_row == '0) || ({1'b0, cur_row} == n_last);
         s1_eoi_ff <= ({1'b0, cur_row} == n_last) && ({1'b0, cur_col} == n_last);
      end
      if (s1_valid_ff) begin
         left_flag_ff <= centre_set;
      end
   end

   // cross dilation of the pixel one row up
   always_comb begin
      centre_set = (centre_rd_ff == SET_VALUE);
      any_set = up_rd_ff || left_flag_ff || centre_set || (right_rd_ff == SET_VALUE)
         || (s1_pixel_ff == SET_VALUE);
      if (s1_edge_col_ff) begin
         dilated = centre_rd_ff;
      end else begin
         dilated = any_set ? SET_VALUE : 8'd0;
      end
   end

   // results of the request in the second stage
   always_comb begin
      push.first_valid = s1_valid_ff && s1_dilate_ff;
      push.first.out_value = dilated;
      push.first.last_in_run = !s1_copy_ff;
      push.first.end_of_image = 1'b0;
      push.second_valid = s1_valid_ff && s1_copy_ff;
      push.second.out_value = s1_pixel_ff;
      push.second.last_in_run = 1'b1;
      push.second.end_of_image = s1_eoi_ff;
   end

   bcd_out_queue u_out_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .level  (queue_level),
      .rsp_ch (rsp_ch)
   );

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for binary_cross_dilation. A directed table walks the
// small-image and restart corners, then random images of mixed sizes, with
// random gaps on both channels, are checked pixel by pixel against a
// line-buffer model of the cross dilation kept inside the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import bcd_pkg::*;

   localparam int unsigned MAX_WIDTH = 1024;
   localparam int unsigned RANDOM_ITEMS = 1524;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam logic [CSR_ADDR_W-1:0] IMAGE_SIZE_ADDR = CSR_ADDR_W'(4 * REG_IMAGE_SIZE);
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = CSR_ADDR_W'(4);
   localparam logic [IMAGE_SIZE_W-1:0] SIZE_FIELD_MAX = '1;
   localparam rsp_payload_type NO_PIXEL = '0;

   typedef enum logic [1:0] {
      STEP_PIXEL,
      STEP_SIZE,
      STEP_SPARE
   } step_kind_type;

   // one row of the directed table; typed > 0 means the results are given here
   typedef struct packed {
      step_kind_type           kind;
      logic [IMAGE_SIZE_W-1:0] value;
      logic [7:0]              pix;
      logic                    sof;
      logic [1:0]              typed;
      rsp_payload_type         first;
      rsp_payload_type         second;
   } dir_step_type;

   localparam int DIRECTED_LEN = 30;
   localparam dir_step_type DIRECTED_STEPS [DIRECTED_LEN] = '{
      // straight after reset, no start mark, row 0 is copied out
      '{STEP_PIXEL, 11'd0, 8'hA5, 1'b0, 2'd1, '{8'hA5, 1'b1, 1'b0}, NO_PIXEL},
      '{STEP_PIXEL, 11'd0, 8'hFF, 1'b0, 2'd1, '{8'hFF, 1'b1, 1'b0}, NO_PIXEL},
      // size zero acts as one: every pixel is a whole image
      '{STEP_SIZE, 11'd0, 8'h00, 1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
      '{STEP_PIXEL, 11'd0, 8'h00, 1'b1, 2'd1, '{8'h00, 1'b1, 1'b1}, NO_PIXEL},
      '{STEP_PIXEL, 11'd0, 8'hFF, 1'b0, 2'd1, '{8'hFF, 1'b1, 1'b1}, NO_PIXEL},
      // two by two: all copies, each once
      '{STEP_SIZE, 11'd2, 8'h00, 1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
      '{STEP_PIXEL, 11'd0, 8'h01, 1'b1, 2'd1, '{8'h01, 1'b1, 1'b0}, NO_PIXEL},
      '{STEP_PIXEL, 11'd0, 8'h80, 1'b0, 2'd1, '{8'h80, 1'b1, 1'b0}, NO_PIXEL},
      '{STEP_PIXEL, 11'd0, 8'h7F, 1'b0, 2'd1, '{8'h7F, 1'b1, 1'b0}, NO_PIXEL},
      '{STEP_PIXEL, 11'd0, 8'hFE, 1'b0, 2'd1, '{8'hFE, 1'b1, 1'b1}, NO_PIXEL},
      // three by three: set pixel above the only interior one
      '{STEP_SIZE, 11'd3, 8'h00, 1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
      '{STEP_PIXEL, 11'd0, 8'h00, 1'b1, 2'd0, NO_PIXEL, NO_PIXEL},
      '{STEP_PIXEL, 11'd0, 8'hFF, 1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
      '{STEP_PIXEL, 11'd0, 8'h00, 1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
      '{STEP_PIXEL, 11'd0, 8'h09, 1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
      '{STEP_PIXEL, 11'd0, 8'h00, 1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
      '{STEP_PIXEL, 11'd0, 8'hFE, 1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
      '{STEP_PIXEL, 11'd0, 8'h00, 1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
      '{STEP_PIXEL, 11'd0, 8'h00, 1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
      '{STEP_PIXEL, 11'd0, 8'h00, 1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
      // four by four, stopped inside row 1
      '{STEP_SIZE, 11'd4, 8'h00, 1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
      '{STEP_PIXEL, 11'd0, 8'h11, 1'b1, 2'd0, NO_PIXEL, NO_PIXEL},
      '{STEP_PIXEL, 11'd0, 8'h22, 1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
      '{STEP_PIXEL, 11'd0, 8'h33, 1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
      '{STEP_PIXEL, 11'd0, 8'h44, 1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
      '{STEP_PIXEL, 11'd0, 8'h55, 1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
      '{STEP_PIXEL, 11'd0, 8'h66, 1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
      // size lowered under the position: next pixel starts a new image
      '{STEP_SIZE, 11'd1, 8'h00, 1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
      // write to an unmapped register must change nothing
      '{STEP_SPARE, 11'd7, 8'h00, 1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
      '{STEP_PIXEL, 11'd0, 8'h33, 1'b0, 2'd1, '{8'h33, 1'b1, 1'b1}, NO_PIXEL}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   bcd_stream_if #(.payload_type(req_payload_type)) req_ch ();
   bcd_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   // model state of the line buffers
   logic [IMAGE_SIZE_W-1:0] size_reg = IMAGE_SIZE_RESET;
   int unsigned next_row = 0;
   int unsigned next_col = 0;
   bit [7:0] above_values [MAX_WIDTH];
   bit       above_set [MAX_WIDTH];

   rsp_payload_type expected_pixels [$];
   int unsigned mismatches = 0;
   bit req_steady = 1'b0;
   bit rsp_steady = 1'b0;

   binary_cross_dilation #(.MAX_WIDTH(MAX_WIDTH)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
   end

   // hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic flag_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   function automatic int unsigned effective_size();
      if (size_reg == 0)
         return 1;
      if (size_reg > MAX_WIDTH)
         return MAX_WIDTH;
      return 32'(size_reg);
   endfunction

   // one pixel through the line buffers; returns how many output pixels it causes
   function automatic int dilate_step(input logic [7:0] pix, input logic sof,
                                      output rsp_payload_type res [2]);
      int unsigned n;
      int unsigned r;
      int unsigned c;
      int cnt;
      logic [7:0] centre;
      logic hit;
      n = effective_size();
      cnt = 0;
      res[0] = '0;
      res[1] = '0;
      if (sof || next_row >= n || next_col >= n) begin
         next_row = 0;
         next_col = 0;
      end
      r = next_row;
      c = next_col;
      // finished pixel of the row above
      if (r >= 2) begin
         centre = above_values[c];
         if (c == 0 || c == n - 1) begin
            res[cnt].out_value = centre;
         end else begin
            hit = above_set[c] || above_set[c - 1] || centre == SET_VALUE ||
                  above_values[c + 1] == SET_VALUE || pix == SET_VALUE;
            res[cnt].out_value = hit ? SET_VALUE : 8'd0;
         end
         cnt++;
      end
      // first and last rows are copied through
      if (r == 0 || r == n - 1) begin
         res[cnt].out_value = pix;
         res[cnt].end_of_image = (r == n - 1 && c == n - 1);
         cnt++;
      end
      if (cnt > 0)
         res[cnt - 1].last_in_run = 1'b1;
      above_set[c] = (above_values[c] == SET_VALUE);
      above_values[c] = pix;
      next_col = c + 1;
      if (next_col >= n) begin
         next_col = 0;
         next_row = r + 1;
         if (next_row >= n)
            next_row = 0;
      end
      return cnt;
   endfunction

   // hand one pixel over and queue what it should produce
   task automatic stream_pixel(input logic [7:0] pix, input logic sof, input int typed = 0,
                               input rsp_payload_type first = '0,
                               input rsp_payload_type second = '0);
      req_payload_type word;
      rsp_payload_type res [2];
      int unsigned gap;
      int cnt;
      word.pixel_value = pix;
      word.start_of_image = sof;
      gap = req_steady ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.payload <= word;
      req_ch.valid <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      cnt = dilate_step(pix, sof, res);
      if (typed != 0) begin
         cnt = typed;
         res[0] = first;
         res[1] = second;
      end
      for (int k = 0; k < cnt; k++)
         expected_pixels.push_back(res[k]);
   endtask

   // stop requests and let every queued result come back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic csr_read(input logic [CSR_ADDR_W-1:0] addr,
                           output logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      data = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // new image size, written while idle and read back
   task automatic set_image_size(input logic [IMAGE_SIZE_W-1:0] value);
      logic [CSR_DATA_W-1:0] rd;
      drain_results();
      csr_write(IMAGE_SIZE_ADDR, CSR_DATA_W'(value));
      csr_read(IMAGE_SIZE_ADDR, rd);
      if (rd !== CSR_DATA_W'(value))
         flag_mismatch("image_size readback", rd, value);
      size_reg = value;
   endtask

   // result side: check each output pixel, then stall at random
   initial begin : result_check
      rsp_payload_type got;
      rsp_payload_type want;
      int unsigned stall;
      rsp_ch.ready = 1'b1;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (expected_pixels.size() == 0) begin
               flag_mismatch("unexpected output pixel", got.out_value, -1);
            end else begin
               want = expected_pixels.pop_front();
               if (got.out_value !== want.out_value)
                  flag_mismatch("out_value", got.out_value, want.out_value);
               if (got.last_in_run !== want.last_in_run)
                  flag_mismatch("last_in_run", got.last_in_run, want.last_in_run);
               if (got.end_of_image !== want.end_of_image)
                  flag_mismatch("end_of_image", got.end_of_image, want.end_of_image);
            end
            if ($urandom_range(0, 39) == 0)
               rsp_steady = !rsp_steady;
            stall = rsp_steady ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_ch.ready <= 1'b1;
            end
         end
      end
   end

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] rd;
      dir_step_type step;
      logic [IMAGE_SIZE_W-1:0] new_size;
      logic [7:0] pix;
      logic sof;
      int unsigned random_count;
      int unsigned n;
      int unsigned len;
      int unsigned hi;
      int unsigned density;
      bit need_sof;
      bit force_resize;
      bit wide_done;
      random_count = 0;
      force_resize = 1'b0;
      wide_done = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      csr_read(IMAGE_SIZE_ADDR, rd);
      if (rd !== CSR_DATA_W'(IMAGE_SIZE_RESET))
         flag_mismatch("image_size after reset", rd, IMAGE_SIZE_RESET);

      // directed table
      for (int i = 0; i < DIRECTED_LEN; i++) begin
         step = DIRECTED_STEPS[i];
         case (step.kind)
            STEP_SIZE: begin
               set_image_size(step.value);
            end
            STEP_SPARE: begin
               drain_results();
               csr_write(SPARE_ADDR, CSR_DATA_W'(step.value));
            end
            default: begin
               stream_pixel(step.pix, step.sof, step.typed, step.first, step.second);
            end
         endcase
      end

      // random images, mostly whole, some cut short or restarted
      while (random_count < RANDOM_ITEMS) begin
         req_steady = ($urandom_range(0, 3) == 0);

         // once: widest images, with the size field saturated and then exact
         if (!wide_done) begin
            set_image_size(SIZE_FIELD_MAX);
            for (int i = 0; i < MAX_WIDTH + 16; i++)
               stream_pixel(8'($urandom_range(0, 255)), i == 0);
            set_image_size(IMAGE_SIZE_W'(MAX_WIDTH));
            for (int i = 0; i < 8; i++)
               stream_pixel(8'($urandom_range(0, 255)), i == 0);
            random_count += MAX_WIDTH + 24;
            wide_done = 1'b1;
            force_resize = 1'b1;
         end

         if (force_resize || $urandom_range(0, 3) == 0) begin
            hi = (next_row > next_col) ? next_row : next_col;
            if (force_resize && hi >= 1 && $urandom_range(0, 1) == 1) begin
               // lowered under the current position: restart without a mark
               new_size = IMAGE_SIZE_W'($urandom_range(1, hi));
            end else begin
               case ($urandom_range(0, 19))
                  0: new_size = '0;
                  1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13:
                     new_size = IMAGE_SIZE_W'($urandom_range(1, 6));
                  19: new_size = IMAGE_SIZE_W'($urandom_range(17, 32));
                  default: new_size = IMAGE_SIZE_W'($urandom_range(7, 16));
               endcase
            end
            set_image_size(new_size);
            force_resize = 1'b0;
         end else if ($urandom_range(0, 9) == 0) begin
            drain_results();
         end

         n = effective_size();
         need_sof = !((next_row == 0 && next_col == 0) || next_row >= n || next_col >= n);
         len = n * n;
         if (len > 1 && $urandom_range(0, 4) == 0) begin
            len = $urandom_range(1, len - 1);
            force_resize = ($urandom_range(0, 1) == 1);
         end
         // last image stops at the item budget
         if (random_count + len > RANDOM_ITEMS)
            len = RANDOM_ITEMS - random_count;
         density = $urandom_range(0, 2);
         for (int i = 0; i < len; i++) begin
            if (i == 0)
               sof = need_sof || ($urandom_range(0, 1) == 1);
            else
               sof = ($urandom_range(0, 255) == 0);
            // set pixels at a per-image density, the rest zero or noise
            if ($urandom_range(0, 9) < 2 + 3 * density)
               pix = SET_VALUE;
            else if ($urandom_range(0, 3) == 0)
               pix = 8'($urandom_range(0, 255));
            else
               pix = 8'd0;
            stream_pixel(pix, sof);
         end
         random_count += len;
      end

      drain_results();
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== binary_cross_dilation.f =====
sv/bcd_pkg.sv
sv/bcd_stream_if.sv
sv/bcd_out_queue.sv
sv/binary_cross_dilation.sv
test/tb.sv
